[sv/ttps_pkg.sv]
// Package for the two/three power sum split block.
// Holds the power-of-three constant table and the status type of the subtract unit.
// No dependencies.
package ttps_pkg;

  // Output exponent field width.
  localparam int EXP_W = 5;

  // Depth of the constant table; covers the largest supported table size.
  localparam int POW3_DEPTH = 40;

  // Powers of three, 3^0 up to 3^39.
  localparam logic [63:0] POW3_TABLE [0:POW3_DEPTH-1] = '{
    64'd1, 64'd3, 64'd9, 64'd27, 64'd81,
    64'd243, 64'd729, 64'd2187, 64'd6561, 64'd19683,
    64'd59049, 64'd177147, 64'd531441, 64'd1594323, 64'd4782969,
    64'd14348907, 64'd43046721, 64'd129140163, 64'd387420489, 64'd1162261467,
    64'd3486784401, 64'd10460353203, 64'd31381059609, 64'd94143178827,
    64'd282429536481, 64'd847288609443, 64'd2541865828329, 64'd7625597484987,
    64'd22876792454961, 64'd68630377364883, 64'd205891132094649,
    64'd617673396283947, 64'd1853020188851841, 64'd5559060566555523,
    64'd16677181699666569, 64'd50031545098999707, 64'd150094635296999121,
    64'd450283905890997363, 64'd1350851717672992089, 64'd4052555153018976267
  };

  // Status of one compare-and-subtract against a table entry.
  typedef struct packed {
    logic fits;  // table entry is not above the residue
    logic zero;  // residue minus entry is zero
  } ttps_sub_status_t;

endpackage

[sv/two_three_power_sum_split_core.sv]
// Top level of the two/three power sum split block.
// Depends on ttps_pkg and ttps_pow3_sub.
// Sequencer, term registers and output register.
//
// Splits a positive integer into terms 2^a * 3^b, none dividing another, and
// sends one output transaction per term in order; the final term has
// last_term_o set, and a zero input produces no output at all. The block
// takes one input transaction at a time and holds in_stall_o high until the
// final term has been loaded into the output register. For each value it
// accepts the value, strips trailing zero bits one bit per cycle (at most
// VALUE_BITS-1 in total), checks that the residue is odd, steps down the
// power-of-three table with the single compare/subtract unit (the search
// resumes from the previous term's exponent), and loads the term into the
// output register, where the load waits while the output is stalled; the
// strip, check, search and load steps repeat for each term.
module two_three_power_sum_split_core import ttps_pkg::*; #(
  parameter int VALUE_BITS   = 31,
  parameter int POW3_ENTRIES = 20,
  parameter int MAX_TERMS    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [EXP_W-1:0]      pow2_exp_o,
  output logic [EXP_W-1:0]      pow3_exp_o,
  output logic                  last_term_o
);

  localparam int SHIFT_W = $clog2(VALUE_BITS);
  localparam int KIDX_W  = $clog2(POW3_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_TERMS);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STRIP  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] residue_q, residue_d;
  logic [SHIFT_W-1:0]    shift_q, shift_d;
  logic [KIDX_W-1:0]     kidx_q, kidx_d;
  logic [KIDX_W-1:0]     term_k_q, term_k_d;
  logic                  term_last_q, term_last_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [EXP_W-1:0]      pow2_q, pow3_q;
  logic                  last_q;
  logic                  out_load;

  logic [VALUE_BITS-1:0] sub_diff;
  ttps_sub_status_t      sub_status;

  // Shared compare-and-subtract unit.
  ttps_pow3_sub #(
    .VALUE_BITS  (VALUE_BITS),
    .POW3_ENTRIES(POW3_ENTRIES)
  ) u_pow3_sub (
    .residue_i(residue_q),
    .kidx_i   (kidx_q),
    .diff_o   (sub_diff),
    .status_o (sub_status)
  );

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer: strip zeros, search the table downward, load one term.
  always_comb begin
    state_d     = state_q;
    residue_d   = residue_q;
    shift_d     = shift_q;
    kidx_d      = kidx_q;
    term_k_d    = term_k_q;
    term_last_d = term_last_q;
    count_d     = count_q;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          residue_d = value_i;
          shift_d   = '0;
          count_d   = '0;
          kidx_d    = KIDX_W'(POW3_ENTRIES - 1);
          if (value_i != '0) begin
            state_d = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (!residue_q[0]) begin
          residue_d = residue_q >> 1;
          shift_d   = shift_q + 1'b1;
        end else if (residue_q == VALUE_BITS'(1)) begin
          // A residue of one closes the sum with a pure power of two.
          term_k_d    = '0;
          term_last_d = 1'b1;
          state_d     = ST_EMIT;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // Exponent one always fits here, since the residue is odd and above one.
        if (sub_status.fits) begin
          residue_d   = sub_diff;
          term_k_d    = kidx_q;
          term_last_d = sub_status.zero || (count_q == CNT_W'(MAX_TERMS - 1));
          state_d     = ST_EMIT;
        end else begin
          kidx_d = kidx_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          count_d  = count_q + 1'b1;
          state_d  = term_last_q ? ST_IDLE : ST_STRIP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the current value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      residue_q   <= '0;
      shift_q     <= '0;
      kidx_q      <= '0;
      term_k_q    <= '0;
      term_last_q <= 1'b0;
    end else begin
      residue_q   <= residue_d;
      shift_q     <= shift_d;
      kidx_q      <= kidx_d;
      term_k_q    <= term_k_d;
      term_last_q <= term_last_d;
    end
  end

  // Output register; holds while the transaction is stalled. Exponents are
  // cut to the width of the output fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow2_q <= '0;
      pow3_q <= '0;
      last_q <= 1'b0;
    end else if (out_load) begin
      pow2_q <= EXP_W'(shift_q);
      pow3_q <= EXP_W'(term_k_q);
      last_q <= term_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pow2_exp_o  = pow2_q;
  assign pow3_exp_o  = pow3_q;
  assign last_term_o = last_q;

endmodule

[sv/ttps_pow3_sub.sv]
// Shared compare-and-subtract unit: residue minus one power of three.
// Depends on ttps_pkg for the power-of-three table and the status type.
// The borrow of the subtraction doubles as the compare result.
module ttps_pow3_sub import ttps_pkg::*; #(
  parameter int VALUE_BITS   = 31,
  parameter int POW3_ENTRIES = 20
) (
  input  logic [VALUE_BITS-1:0]           residue_i,
  input  logic [$clog2(POW3_ENTRIES)-1:0] kidx_i,
  output logic [VALUE_BITS-1:0]           diff_o,
  output ttps_sub_status_t                status_o
);

  logic [5:0]  tab_idx;
  logic [63:0] entry;
  logic [64:0] wide_diff;

  // Look up the table entry and subtract it at full table width.
  assign tab_idx   = 6'(kidx_i);
  assign entry     = POW3_TABLE[tab_idx];
  assign wide_diff = {1'b0, 64'(residue_i)} - {1'b0, entry};

  // No borrow means the entry fits; the low bits are then the new residue.
  assign diff_o        = wide_diff[VALUE_BITS-1:0];
  assign status_o.fits = ~wide_diff[64];
  assign status_o.zero = (wide_diff[63:0] == 64'd0);

endmodule

[sv/ttps_checker.sv]
// Port-level checker for the two/three power sum split block.
// Depends on ttps_pkg; bound to two_three_power_sum_split_core below.
module ttps_checker import ttps_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [VALUE_BITS-1:0] value_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [EXP_W-1:0]      pow2_exp_o,
  input logic [EXP_W-1:0]      pow3_exp_o,
  input logic                  last_term_o
);

  // A zero value is consumed without any work: the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (value_i == '0) |=> !in_stall_o)
    else $error("zero value left the block busy");

  // A nonzero value keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (value_i != '0) |=> in_stall_o)
    else $error("block ready right after taking a nonzero value");

  // While a non-final term leaves, the decomposition is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_term_o |-> in_stall_o)
    else $error("block idle before the final term was produced");

  // A stalled output transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pow2_exp_o) &&
      $stable(pow3_exp_o) && $stable(last_term_o))
    else $error("stalled output transaction changed");

endmodule

bind two_three_power_sum_split_core ttps_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_ttps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .value_i    (value_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .pow2_exp_o (pow2_exp_o),
  .pow3_exp_o (pow3_exp_o),
  .last_term_o(last_term_o)
);
